// ===== sv/assoc_page_table_fifo_lru_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros for the page table block
// short wrappers around concurrent assertions clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSOC_PAGE_TABLE_FIFO_LRU_MACROS_SVH
`define ASSOC_PAGE_TABLE_FIFO_LRU_MACROS_SVH

// condition holds at every clock edge out of reset
`define APT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define APT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// antecedent implies consequent at the same edge
`define APT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/apt_pkg.sv =====
// ----------------------------------------------------------------------------
// apt_pkg
// shared constants, codes and types of the associative page table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package apt_pkg;

    // defaults for the top level parameters
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int PAGE_BITS_DEF   = 20;

    // fixed field widths
    localparam int FRAME_W   = 4;
    localparam int TSIZE_W   = 5;
    localparam int LT_W      = 8;
    localparam int TIME_W    = 9;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;

    // fixed penalty charged, when enabled, on a replacement with the tlb missed flag clear
    localparam int PENALTY = 20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PENALTY_ENABLE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOOKUP_TIME    = 2'd3;

    // replacement policy codes
    localparam logic MODE_FIFO = 1'b0;
    localparam logic MODE_LRU  = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } apt_state_t;

    // update commands broadcast to the row of cells
    typedef struct packed {
        logic shift;     // lru move: cells from idx below last take the neighbor, last takes the load
        logic wr;        // write the load page into the cell at idx
        logic wr_frame;  // with wr, also write the load frame
    } cell_ctrl_t;

endpackage

// ===== sv/apt_cell.sv =====
// ----------------------------------------------------------------------------
// apt_cell
// one table entry: holds page and frame, compares against the lookup page,
// and takes its right neighbor's entry during an lru move
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apt_cell
    import apt_pkg::*;
#(
    parameter int POS       = 0,
    parameter int IDX_W     = 4,
    parameter int CNT_W     = 5,
    parameter int PAGE_BITS = PAGE_BITS_DEF
)
(
    input  logic                 clk,
    input  cell_ctrl_t           ctrl,
    input  logic [IDX_W-1:0]     idx,
    input  logic [IDX_W-1:0]     last,
    input  logic [CNT_W-1:0]     fill,
    input  logic [PAGE_BITS-1:0] ld_page,
    input  logic [FRAME_W-1:0]   ld_frame,
    input  logic [PAGE_BITS-1:0] nbr_page,
    input  logic [FRAME_W-1:0]   nbr_frame,
    input  logic [PAGE_BITS-1:0] cmp_page,
    output logic [PAGE_BITS-1:0] page,
    output logic [FRAME_W-1:0]   frame,
    output logic                 match
);

    localparam logic [IDX_W-1:0] POS_I = IDX_W'(POS);
    localparam logic [CNT_W-1:0] POS_C = CNT_W'(POS);

    logic [PAGE_BITS-1:0] page_reg;
    logic [FRAME_W-1:0]   frame_reg;

    // entry update: lru move or direct write
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            if (POS_I == last)
            begin
                page_reg  <= ld_page;
                frame_reg <= ld_frame;
            end
            else if (POS_I >= idx && POS_I < last)
            begin
                page_reg  <= nbr_page;
                frame_reg <= nbr_frame;
            end
        end
        else if (ctrl.wr && POS_I == idx)
        begin
            page_reg <= ld_page;
            if (ctrl.wr_frame)
            begin
                frame_reg <= ld_frame;
            end
        end
    end

    // compare only while the entry is held
    assign match = (POS_C < fill) && (page_reg == cmp_page);
    assign page  = page_reg;
    assign frame = frame_reg;

endmodule

// ===== sv/assoc_page_table_fifo_lru.sv =====
// Fully associative page table built as a row of MAX_ENTRIES cells, kept in
// use order under lru. A word passes a compare state, which registers the
// match of every cell against the page, then an update state, which picks the
// lowest matching cell, drives the update into the cells (fill, fifo
// overwrite, or an lru move where each cell takes its neighbor's entry) and
// loads the result register. A new word is accepted while idle, or in the
// update state when the result register is free; a stalled result holds the
// block in its update state. No clearing pass follows reset.
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// assoc_page_table_fifo_lru
// page translation table with fifo or lru replacement and access time report
// ----------------------------------------------------------------------------

`include "assoc_page_table_fifo_lru_macros.svh"

module assoc_page_table_fifo_lru
    import apt_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int PAGE_BITS   = PAGE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // input words
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PAGE_BITS-1:0] logic_page,
    input  logic                 tlb_missed_flag,
    // result words
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [FRAME_W-1:0]   frame,
    output logic                 page_hit,
    output logic                 evicted_valid,
    output logic [PAGE_BITS-1:0] evicted_page,
    output logic [TIME_W-1:0]    time_added
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int SZ_W  = (CNT_W > TSIZE_W) ? CNT_W : TSIZE_W;

    // configuration registers
    logic [TSIZE_W-1:0] table_size_reg;
    logic               replace_mode_reg;
    logic               penalty_enable_reg;
    logic [LT_W-1:0]    lookup_time_reg;

    // control state
    apt_state_t       state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0] fifo_reg, fifo_next;
    logic             out_valid_reg, out_valid_next;

    // captured word and match vector
    logic [PAGE_BITS-1:0]   page_reg;
    logic                   tlb_reg;
    logic [MAX_ENTRIES-1:0] match_reg;

    // result registers
    logic [FRAME_W-1:0]   frame_reg;
    logic                 hit_reg;
    logic                 ev_valid_reg;
    logic [PAGE_BITS-1:0] ev_page_reg;
    logic [TIME_W-1:0]    time_reg;

    // cell row
    logic [PAGE_BITS-1:0]   cell_page [MAX_ENTRIES];
    logic [FRAME_W-1:0]     cell_frame[MAX_ENTRIES];
    logic [PAGE_BITS-1:0]   nbr_page  [MAX_ENTRIES];
    logic [FRAME_W-1:0]     nbr_frame [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] cell_match;

    cell_ctrl_t           ctrl;
    logic [IDX_W-1:0]     ctrl_idx;
    logic [IDX_W-1:0]     ctrl_last;
    logic [PAGE_BITS-1:0] ld_page;
    logic [FRAME_W-1:0]   ld_frame;

    // decision signals
    logic                     slot_free;
    logic                     in_acc;
    logic                     do_upd;
    logic                     hit;
    logic [IDX_W-1:0]         hit_idx;
    logic [SZ_W-1:0]          ts_ext;
    logic [SZ_W-1:0]          limit_ext;
    logic [CNT_W-1:0]         limit;
    logic                     full;
    logic [IDX_W-1:0]         victim;
    logic [IDX_W-1:0]         victim_raw;
    logic [CNT_W+FRAME_W-1:0] fill_wide;
    logic [FRAME_W-1:0]       fill_frame;
    logic                     pen;

    logic [FRAME_W-1:0]   res_frame;
    logic                 res_ev_valid;
    logic [PAGE_BITS-1:0] res_ev_page;
    logic [TIME_W-1:0]    res_time;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg     <= TSIZE_W'(16);
            replace_mode_reg   <= MODE_FIFO;
            penalty_enable_reg <= 1'b0;
            lookup_time_reg    <= LT_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TABLE_SIZE:     table_size_reg     <= cfg_data[TSIZE_W-1:0];
                REG_REPLACE_MODE:   replace_mode_reg   <= cfg_data[0];
                REG_PENALTY_ENABLE: penalty_enable_reg <= cfg_data[0];
                REG_LOOKUP_TIME:    lookup_time_reg    <= cfg_data[LT_W-1:0];
                default:            table_size_reg     <= table_size_reg;
            endcase
        end
    end

    // handshake
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) || (state_reg == ST_UPD && slot_free);
    assign in_acc    = in_valid && in_ready;
    assign do_upd    = (state_reg == ST_UPD) && slot_free;

    // cell row with neighbor links
    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++)
        begin : g_cell
            if (g < MAX_ENTRIES - 1)
            begin : g_link
                assign nbr_page[g]  = cell_page[g+1];
                assign nbr_frame[g] = cell_frame[g+1];
            end
            else
            begin : g_end
                assign nbr_page[g]  = '0;
                assign nbr_frame[g] = '0;
            end

            apt_cell #(
                .POS       (g),
                .IDX_W     (IDX_W),
                .CNT_W     (CNT_W),
                .PAGE_BITS (PAGE_BITS)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .idx       (ctrl_idx),
                .last      (ctrl_last),
                .fill      (fill_reg),
                .ld_page   (ld_page),
                .ld_frame  (ld_frame),
                .nbr_page  (nbr_page[g]),
                .nbr_frame (nbr_frame[g]),
                .cmp_page  (page_reg),
                .page      (cell_page[g]),
                .frame     (cell_frame[g]),
                .match     (cell_match[g])
            );
        end
    endgenerate

    // lowest matching cell
    always_comb
    begin
        hit_idx = '0;
        for (int k = MAX_ENTRIES - 1; k >= 0; k--)
        begin
            if (match_reg[k])
            begin
                hit_idx = IDX_W'(k);
            end
        end
    end
    assign hit = |match_reg;

    // effective table size, clamped to one and to the row length
    assign ts_ext    = SZ_W'(table_size_reg);
    assign limit_ext = (ts_ext == '0) ? SZ_W'(1) :
                       (ts_ext > SZ_W'(MAX_ENTRIES)) ? SZ_W'(MAX_ENTRIES) : ts_ext;
    assign limit     = limit_ext[CNT_W-1:0];
    assign full      = (fill_reg >= limit);

    // victim choice
    assign victim_raw = (replace_mode_reg == MODE_FIFO) ? fifo_reg : '0;
    assign victim     = (CNT_W'(victim_raw) >= fill_reg) ? '0 : victim_raw;

    // new frame for a fill is the fill count
    assign fill_wide  = {{FRAME_W{1'b0}}, fill_reg};
    assign fill_frame = fill_wide[FRAME_W-1:0];

    assign pen = penalty_enable_reg && !tlb_reg;

    // update decision and result
    always_comb
    begin
        ctrl         = '0;
        ctrl_idx     = '0;
        ctrl_last    = fill_reg[IDX_W-1:0] - IDX_W'(1);
        ld_page      = page_reg;
        ld_frame     = fill_frame;
        fill_next    = fill_reg;
        fifo_next    = fifo_reg;
        res_frame    = fill_frame;
        res_ev_valid = 1'b0;
        res_ev_page  = '0;
        res_time     = TIME_W'(lookup_time_reg);

        if (hit)
        begin
            res_frame = cell_frame[hit_idx];
            if (replace_mode_reg == MODE_LRU)
            begin
                ctrl.shift = do_upd;
                ctrl_idx   = hit_idx;
                ld_page    = cell_page[hit_idx];
                ld_frame   = cell_frame[hit_idx];
            end
        end
        else if (!full)
        begin
            ctrl.wr       = do_upd;
            ctrl.wr_frame = 1'b1;
            ctrl_idx      = fill_reg[IDX_W-1:0];
            if (do_upd)
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end
        else
        begin
            res_ev_valid = 1'b1;
            res_ev_page  = cell_page[victim];
            res_frame    = cell_frame[victim];
            if (pen)
            begin
                res_time = TIME_W'(lookup_time_reg) + TIME_W'(PENALTY);
            end
            if (replace_mode_reg == MODE_FIFO)
            begin
                ctrl.wr  = do_upd;
                ctrl_idx = victim;
                if (do_upd)
                begin
                    fifo_next = (CNT_W'(victim) + CNT_W'(1) == fill_reg) ?
                                '0 : victim + IDX_W'(1);
                end
            end
            else
            begin
                ctrl.shift = do_upd;
                ctrl_idx   = '0;
                ld_frame   = cell_frame[0];
            end
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (do_upd)
                begin
                    out_valid_next = 1'b1;
                    state_next     = in_acc ? ST_CMP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            fifo_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            fifo_reg      <= fifo_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // captured word, match vector and result payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            page_reg <= logic_page;
            tlb_reg  <= tlb_missed_flag;
        end
        if (state_reg == ST_CMP)
        begin
            match_reg <= cell_match;
        end
        if (do_upd)
        begin
            frame_reg    <= res_frame;
            hit_reg      <= hit;
            ev_valid_reg <= res_ev_valid;
            ev_page_reg  <= res_ev_page;
            time_reg     <= res_time;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame         = frame_reg;
    assign page_hit      = hit_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign time_added    = time_reg;

    // checks
    `APT_ASSERT_NEXT(a_two_cycle_gap, in_valid && in_ready, !in_ready,
        "word accepted in back to back cycles")
    `APT_ASSERT_ALWAYS(a_fill_bound, fill_reg <= CNT_W'(MAX_ENTRIES),
        "fill count beyond table length")
    `APT_ASSERT_ALWAYS(a_fifo_bound, fifo_reg == '0 || CNT_W'(fifo_reg) < fill_reg,
        "fifo pointer outside held entries")
    `APT_ASSERT_SAME(a_hit_no_evict, out_valid && page_hit, !evicted_valid,
        "hit result reports an eviction")

endmodule

// ===== dv/tb_assoc_page_table_fifo_lru.sv =====
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// tb_assoc_page_table_fifo_lru
// self-checking bench for the associative page table with fifo / lru refill.
// a directed table covers reset behavior, extremes, table size wrap and
// saturation, shrinking below the held count and policy switches; random
// phases then reprogram the registers and send page streams drawn from small
// pools so hits, fills and evictions all occur. every result word is matched
// field by field against an in-bench translation model or a typed result.
// ----------------------------------------------------------------------------

module tb_assoc_page_table_fifo_lru
    import apt_pkg::*;
();

    localparam int PAGE_W      = PAGE_BITS_DEF;
    localparam int DEPTH       = MAX_ENTRIES_DEF;
    localparam int TOTAL_WORDS = 1300;
    localparam int DRAIN_GAP   = 4;
    localparam int HOLD_CYCLES = 80;
    localparam int DIR_N       = 31;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               hit;
        logic               ev_valid;
        logic [PAGE_W-1:0]  ev_page;
        logic [TIME_W-1:0]  acc_time;
    } xlat_t;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        logic [PAGE_W-1:0]    pg;
        logic                 tlb;
        bit                   typed;
        xlat_t                want;
    } step_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [PAGE_W-1:0]    logic_page;
    logic                 tlb_missed_flag;
    logic                 out_valid;
    logic                 out_ready;
    logic [FRAME_W-1:0]   frame;
    logic                 page_hit;
    logic                 evicted_valid;
    logic [PAGE_W-1:0]    evicted_page;
    logic [TIME_W-1:0]    time_added;

    // translation model state and register shadows
    logic [PAGE_W-1:0]    tbl_page [DEPTH];
    logic [FRAME_W-1:0]   tbl_frame [DEPTH];
    int                   held_cnt = 0;
    int                   fifo_ptr = 0;
    logic [TSIZE_W-1:0]   sh_size = 5'd16;
    logic                 sh_mode = MODE_FIFO;
    logic                 sh_pen = 1'b0;
    logic [LT_W-1:0]      sh_lookup = 8'd1;

    xlat_t                pending_xlat [$];
    logic [PAGE_W-1:0]    page_pool [$];
    int                   err_cnt = 0;
    int                   words_sent = 0;
    int                   words_seen = 0;
    int                   hit_cnt = 0;
    int                   evict_cnt = 0;
    int                   reg_writes = 0;
    int                   phase_cnt = 0;
    int                   long_holds = 0;
    bit                   stall_req = 1'b0;
    bit                   cfg_active = 1'b0;
    bit                   no_idle = 1'b0;

    // directed steps: register writes and words, typed results where obvious
    step_t dir_steps [DIR_N] = '{
        '{1'b0, REG_TABLE_SIZE, 8'd0, 20'h00000, 1'b0, 1'b1,
          '{4'd0, 1'b0, 1'b0, 20'h00000, 9'd1}},
        '{1'b0, REG_TABLE_SIZE, 8'd0, 20'hFFFFF, 1'b1, 1'b1,
          '{4'd1, 1'b0, 1'b0, 20'h00000, 9'd1}},
        '{1'b0, REG_TABLE_SIZE, 8'd0, 20'h00000, 1'b1, 1'b1,
          '{4'd0, 1'b1, 1'b0, 20'h00000, 9'd1}},
        '{1'b0, REG_TABLE_SIZE, 8'd0, 20'h5A5A5, 1'b0, 1'b1,
          '{4'd2, 1'b0, 1'b0, 20'h00000, 9'd1}},
        '{1'b1, REG_TABLE_SIZE, 8'd2, 20'h0, 1'b0, 1'b0, '0},
        '{1'b1, REG_PENALTY_ENABLE, 8'd1, 20'h0, 1'b0, 1'b0, '0},
        '{1'b1, REG_LOOKUP_TIME, 8'd255, 20'h0, 1'b0, 1'b0, '0},
        '{1'b0, REG_TABLE_SIZE, 8'd0, 20'h12345, 1'b0, 1'b1,
          '{4'd0, 1'b0, 1'b1, 20'h00000, 9'd275}},
        '{1'b0, REG_TABLE_SIZE, 8'd0, 20'h00000, 1'b1, 1'b1,
          '{4'd1, 1'b0, 1'b1, 20'hFFFFF, 9'd255}},
        '{1'b0, REG_TABLE_SIZE, 8'd0, 20'h12345, 1'b0, 1'b1,
          '{4'd0, 1'b1, 1'b0, 20'h00000, 9'd255}},
        '{1'b0, REG_TABLE_SIZE, 8'd0, 20'hA5A5A, 1'b0, 1'b1,
          '{4'd2, 1'b0, 1'b1, 20'h5A5A5, 9'd275}},
        '{1'b1, REG_REPLACE_MODE, {7'd0, MODE_LRU}, 20'h0, 1'b0, 1'b0, '0},
        '{1'b1, REG_LOOKUP_TIME, 8'd0, 20'h0, 1'b0, 1'b0, '0},
        '{1'b0, REG_TABLE_SIZE, 8'd0, 20'h00000, 1'b0, 1'b0, '0},
        '{1'b0, REG_TABLE_SIZE, 8'd0, 20'h12345, 1'b1, 1'b0, '0},
        '{1'b0, REG_TABLE_SIZE, 8'd0, 20'h54321, 1'b0, 1'b0, '0},
        '{1'b1, REG_TABLE_SIZE, 8'd0, 20'h0, 1'b0, 1'b0, '0},
        '{1'b0, REG_TABLE_SIZE, 8'd0, 20'h0F0F0, 1'b1, 1'b0, '0},
        '{1'b0, REG_TABLE_SIZE, 8'd0, 20'h0F0F0, 1'b0, 1'b0, '0},
        '{1'b1, REG_TABLE_SIZE, 8'd31, 20'h0, 1'b0, 1'b0, '0},
        '{1'b1, REG_LOOKUP_TIME, 8'd128, 20'h0, 1'b0, 1'b0, '0},
        '{1'b0, REG_TABLE_SIZE, 8'd0, 20'h80000, 1'b0, 1'b0, '0},
        '{1'b0, REG_TABLE_SIZE, 8'd0, 20'h00001, 1'b1, 1'b0, '0},
        '{1'b0, REG_TABLE_SIZE, 8'd0, 20'h7FFFF, 1'b0, 1'b0, '0},
        '{1'b0, REG_TABLE_SIZE, 8'd0, 20'h40000, 1'b0, 1'b0, '0},
        '{1'b1, REG_REPLACE_MODE, {7'h7F, MODE_FIFO}, 20'h0, 1'b0, 1'b0, '0},
        '{1'b1, REG_PENALTY_ENABLE, 8'hFE, 20'h0, 1'b0, 1'b0, '0},
        '{1'b1, REG_TABLE_SIZE, 8'd4, 20'h0, 1'b0, 1'b0, '0},
        '{1'b0, REG_TABLE_SIZE, 8'd0, 20'h33333, 1'b0, 1'b0, '0},
        '{1'b0, REG_TABLE_SIZE, 8'd0, 20'h44444, 1'b1, 1'b0, '0},
        '{1'b0, REG_TABLE_SIZE, 8'd0, 20'h80000, 1'b0, 1'b0, '0}
    };

    assoc_page_table_fifo_lru u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .logic_page      (logic_page),
        .tlb_missed_flag (tlb_missed_flag),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .frame           (frame),
        .page_hit        (page_hit),
        .evicted_valid   (evicted_valid),
        .evicted_page    (evicted_page),
        .time_added      (time_added)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // one line per mismatch
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_cnt++;
        $display("ERROR t=%0t word %0d %s: got %0h expected %0h",
                 $realtime, words_seen, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // lru move: entry at idx goes to the most recent end
    function automatic void move_to_tail(input int idx);
        logic [PAGE_W-1:0]  p;
        logic [FRAME_W-1:0] f;
        p = tbl_page[idx];
        f = tbl_frame[idx];
        for (int k = idx; k + 1 < held_cnt; k++)
        begin
            tbl_page[k]  = tbl_page[k + 1];
            tbl_frame[k] = tbl_frame[k + 1];
        end
        tbl_page[held_cnt - 1]  = p;
        tbl_frame[held_cnt - 1] = f;
    endfunction

    // translate one page and advance the table state
    function automatic xlat_t translate_page(input logic [PAGE_W-1:0] pg,
                                             input logic tlb);
        xlat_t r;
        int    lim;
        int    idx;
        int    v;
        r          = '0;
        r.acc_time = {1'b0, sh_lookup};
        lim        = (sh_size == 0) ? 1 : ((sh_size > DEPTH) ? DEPTH : int'(sh_size));
        idx        = -1;
        for (int k = 0; k < held_cnt; k++)
            if (idx < 0 && tbl_page[k] == pg)
                idx = k;
        if (idx >= 0)
        begin
            // hit
            r.hit   = 1'b1;
            r.frame = tbl_frame[idx];
            if (sh_mode == MODE_LRU)
                move_to_tail(idx);
        end
        else if (held_cnt < lim)
        begin
            // fill into the next free slot
            r.frame             = FRAME_W'(held_cnt);
            tbl_page[held_cnt]  = pg;
            tbl_frame[held_cnt] = FRAME_W'(held_cnt);
            held_cnt++;
        end
        else
        begin
            // replace the fifo victim or the oldest entry
            v = (sh_mode == MODE_FIFO) ? fifo_ptr : 0;
            if (v >= held_cnt)
                v = 0;
            r.ev_valid  = 1'b1;
            r.ev_page   = tbl_page[v];
            r.frame     = tbl_frame[v];
            tbl_page[v] = pg;
            if (sh_mode == MODE_FIFO)
                fifo_ptr = (v + 1) % held_cnt;
            else
                move_to_tail(0);
            if (sh_pen && !tlb)
                r.acc_time = r.acc_time + TIME_W'(PENALTY);
        end
        return r;
    endfunction

    // let the block empty out before touching registers
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_xlat.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    // register write; cfg_we stays high until the caller drops it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_TABLE_SIZE:     sh_size   = val[TSIZE_W-1:0];
            REG_REPLACE_MODE:   sh_mode   = val[0];
            REG_PENALTY_ENABLE: sh_pen    = val[0];
            REG_LOOKUP_TIME:    sh_lookup = val[LT_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // offer one word, hold it until taken, then log its expected result
    task automatic send_word(input logic [PAGE_W-1:0] pg, input logic tlb,
                             input bit use_typed, input xlat_t typed_val);
        xlat_t pred;
        int    gap;
        in_valid        <= 1'b1;
        logic_page      <= pg;
        tlb_missed_flag <= tlb;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        pred = translate_page(pg, tlb);
        pending_xlat.insert(pending_xlat.size(), use_typed ? typed_val : pred);
        words_sent++;
        if (pred.hit)
            hit_cnt++;
        if (pred.ev_valid)
            evict_cnt++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // random register settings for a new phase
    task automatic reprogram(input bit all_regs);
        logic [TSIZE_W-1:0] sz;
        int                 k;
        if (all_regs || $urandom_range(0, 9) < 6)
        begin
            k = $urandom_range(0, 9);
            if (k == 0)
                sz = 5'd0;
            else if (k == 1)
                sz = TSIZE_W'($urandom_range(17, 31));
            else if (k == 2)
                sz = 5'd16;
            else if (k == 3)
                sz = 5'd1;
            else
                sz = TSIZE_W'($urandom_range(1, 16));
            write_reg(REG_TABLE_SIZE, {3'($urandom_range(0, 7)), sz});
        end
        if (all_regs || $urandom_range(0, 1))
            write_reg(REG_REPLACE_MODE, {7'($urandom_range(0, 127)),
                      $urandom_range(0, 1) ? MODE_LRU : MODE_FIFO});
        if (all_regs || $urandom_range(0, 1))
            write_reg(REG_PENALTY_ENABLE, 8'($urandom_range(0, 255)));
        if (all_regs || $urandom_range(0, 1))
        begin
            k = $urandom_range(0, 7);
            write_reg(REG_LOOKUP_TIME, (k == 0) ? 8'd0 : (k == 1) ? 8'd255
                                                 : 8'($urandom_range(0, 255)));
        end
        cfg_we <= 1'b0;
    endtask

    // result side: random ready gaps, plus requested long holds
    initial
    begin
        int gap;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = pick_gap();
            if (stall_req)
            begin
                stall_req = 1'b0;
                long_holds++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            if ($urandom_range(0, 19) == 0)
                repeat (100) @(posedge clk);
            else
                repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        xlat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_xlat.size() == 0)
            begin
                report_mismatch("unexpected word", {31'd0, out_valid}, 32'd0);
            end
            else
            begin
                want = pending_xlat.pop_front();
                check_field("frame", 32'(frame), 32'(want.frame));
                check_field("page_hit", 32'(page_hit), 32'(want.hit));
                check_field("evicted_valid", 32'(evicted_valid), 32'(want.ev_valid));
                check_field("evicted_page", 32'(evicted_page), 32'(want.ev_page));
                check_field("time_added", 32'(time_added), 32'(want.acc_time));
            end
            words_seen++;
        end
    end

    // main sequence
    initial
    begin
        int n;
        int r;
        logic [PAGE_W-1:0] pg;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= REG_TABLE_SIZE;
        cfg_data        <= '0;
        in_valid        <= 1'b0;
        logic_page      <= '0;
        tlb_missed_flag <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIR_N; i++)
        begin
            if (dir_steps[i].is_cfg)
            begin
                if (!cfg_active)
                    wait_idle();
                write_reg(dir_steps[i].reg_idx, dir_steps[i].reg_val);
                cfg_active = 1'b1;
            end
            else
            begin
                if (cfg_active)
                begin
                    cfg_we <= 1'b0;
                    cfg_active = 1'b0;
                end
                send_word(dir_steps[i].pg, dir_steps[i].tlb, dir_steps[i].typed,
                          dir_steps[i].want);
            end
        end

        // random phases over pools of pages so hits and evictions both occur
        while (words_sent < TOTAL_WORDS)
        begin
            wait_idle();
            reprogram(phase_cnt == 0);
            phase_cnt++;
            if (phase_cnt == 3 || phase_cnt == 12)
                stall_req = 1'b1;
            no_idle = ($urandom_range(0, 3) == 0);
            page_pool.delete();
            n = $urandom_range(2, 24);
            for (int i = 0; i < n; i++)
            begin
                if (held_cnt > 0 && $urandom_range(0, 2) == 0)
                    page_pool.insert(page_pool.size(),
                                     tbl_page[$urandom_range(0, held_cnt - 1)]);
                else
                    page_pool.insert(page_pool.size(), PAGE_W'($urandom));
            end
            n = $urandom_range(30, 90);
            for (int i = 0; i < n; i++)
            begin
                r = $urandom_range(0, 9);
                if (r < 7)
                    pg = page_pool[$urandom_range(0, page_pool.size() - 1)];
                else if (r == 7 && held_cnt > 0)
                    pg = tbl_page[$urandom_range(0, held_cnt - 1)];
                else
                    pg = PAGE_W'($urandom);
                send_word(pg, 1'($urandom_range(0, 1)), 1'b0, '0);
            end
            no_idle = 1'b0;
        end

        // drain and close out
        wait_idle();
        repeat (10) @(posedge clk);
        if (pending_xlat.size() != 0)
            report_mismatch("words never returned", pending_xlat.size(), 32'd0);
        $display("covered %0d words: %0d hits, %0d evictions, %0d fills",
                 words_sent, hit_cnt, evict_cnt, words_sent - hit_cnt - evict_cnt);
        $display("%0d register writes over %0d random phases, %0d long output holds",
                 reg_writes, phase_cnt, long_holds);
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/apt_pkg.sv
sv/apt_cell.sv
sv/assoc_page_table_fifo_lru.sv
dv/tb_assoc_page_table_fifo_lru.sv
